@@ sv/ascii_angle_frame_to_servo_pulse_defines.svh @@
// ----------------------------------------------------------------------------
// ASCII angle frame to servo pulse: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASCII_ANGLE_FRAME_TO_SERVO_PULSE_DEFINES_SVH
`define ASCII_ANGLE_FRAME_TO_SERVO_PULSE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AAFSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AAFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/aafsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII angle frame to servo pulse: package
// Frame layout, register map, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package aafsp_pkg;

    // frame layout
    localparam int NUM_FIELDS  = 6;
    localparam int FIELD_BYTES = 7;
    localparam int FRAME_BYTES = 41;

    localparam logic [2:0] LAST_FIELD     = 3'(NUM_FIELDS - 1);
    localparam logic [2:0] LAST_DIGIT_POS = 3'd5;
    localparam logic [2:0] LAST_FIELD_POS = 3'(FIELD_BYTES - 1);

    // linear byte offset within a frame: field * FIELD_BYTES + position
    localparam int LIN_W = $clog2(8 * FIELD_BYTES + 1) + 1;
    localparam logic [LIN_W-1:0] LAST_LINEAR = LIN_W'(FRAME_BYTES - 1);

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // register map (word index)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_MAX_MAG = 2'd0;
    localparam logic [1:0] REG_CENTER  = 2'd1;
    localparam logic [1:0] REG_OFFSET  = 2'd2;

    localparam logic [16:0] MAX_MAG_RESET = 17'd4500;
    localparam logic [16:0] CENTER_RESET  = 17'd9000;
    localparam logic [15:0] OFFSET_RESET  = 16'd500;

    localparam logic [16:0] ANGLE_MAX   = 17'h1FFFF;
    localparam logic [15:0] COMPARE_MAX = 16'hFFFF;

    // floor(x / 9) = (x * RECIP_NINE) >> DIV_SHIFT, exact for x < 2^17
    localparam logic [16:0] RECIP_NINE = 17'd116509;
    localparam int DIV_SHIFT = 20;
    localparam int QUOT_W    = 14;

    // per-result tag carried down the pipeline
    typedef struct packed {
        logic [2:0] field;
        logic       err;
        logic       done;
    } aafsp_tag_t;

endpackage

@@ sv/ascii_angle_frame_to_servo_pulse.sv @@
// ----------------------------------------------------------------------------
// ASCII angle frame to servo pulse
// Parses fixed-layout ASCII angle frames and emits per-field servo compares.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one received byte per request, with
//   frame_start marking the sign byte of a frame. Bytes are taken one per
//   cycle while in_ready is high; the parser state updates at the accept edge.
//   Output channel (out_valid/out_ready): one request per completed field,
//   produced by the fifth digit byte. Sign, separator and other digit bytes
//   give no output.
//   Pipeline: a result passes four stage registers (magnitude, clamped
//   angle, divide-by-nine multiply, compare add) on its way to out_valid;
//   the first one loads at the accept edge.
//   Throughput: one byte per cycle while in_ready is high. The four pipeline
//   stages hold only result-bearing requests, each with its own valid, so a
//   stalled receiver blocks input only once every stage ahead of it is full.
//   Config: APB port, registers at 0x0 max_magnitude, 0x4 center_angle,
//   0x8 pulse_offset; written only while the block is idle, a rule on the user that the block does not enforce.
//   Reset: parser back to sign byte of field 0, pipeline emptied,
//   registers to 4500 / 9000 / 500.
// ----------------------------------------------------------------------------
module ascii_angle_frame_to_servo_pulse
    import aafsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        field_index,
    output logic [16:0]       target_angle,
    output logic [15:0]       servo_compare,
    output logic              digit_error,
    output logic              frame_done,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [16:0] max_mag_reg;
    logic [16:0] center_reg;
    logic [15:0] offset_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mag_reg <= MAX_MAG_RESET;
            center_reg  <= CENTER_RESET;
            offset_reg  <= OFFSET_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAX_MAG: max_mag_reg <= pwdata[16:0];
                REG_CENTER:  center_reg  <= pwdata[16:0];
                REG_OFFSET:  offset_reg  <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAX_MAG: prdata = {15'd0, max_mag_reg};
            REG_CENTER:  prdata = {15'd0, center_reg};
            REG_OFFSET:  prdata = {16'd0, offset_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake: each stage loads when empty or moving on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_room, s2_room, s3_room, out_room;
    logic in_fire;

    assign out_room = !out_valid_reg || out_ready;
    assign s3_room  = !s3_valid_reg  || out_room;
    assign s2_room  = !s2_valid_reg  || s3_room;
    assign s1_room  = !s1_valid_reg  || s2_room;
    assign in_ready = s1_room;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // byte parser
    // ------------------------------------------------------------------
    logic [2:0]       byte_pos_reg, byte_pos_next;
    logic [2:0]       field_cnt_reg, field_cnt_next;
    logic [16:0]      acc_reg, acc_next;
    logic             sign_plus_reg, sign_plus_next;
    logic             err_seen_reg, err_seen_next;

    logic [2:0]       pos_cur, fc_cur;
    logic             digit_ok;
    logic [3:0]       digit;
    logic [20:0]      acc_scaled;
    logic [LIN_W-1:0] linear;
    logic             emit, done;

    always_comb
    begin
        pos_cur  = frame_start ? 3'd0 : byte_pos_reg;
        fc_cur   = frame_start ? 3'd0 : field_cnt_reg;
        digit_ok = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
        // the low nibble of '0'..'9' is the digit value
        digit    = digit_ok ? rx_byte[3:0] : 4'd0;
        // acc * 10 + digit as shifts
        acc_scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {17'd0, digit};

        sign_plus_next = sign_plus_reg;
        acc_next       = acc_reg;
        err_seen_next  = err_seen_reg;
        emit           = 1'b0;

        if (pos_cur == 3'd0)
        begin
            sign_plus_next = (rx_byte == ASCII_ZERO);
            acc_next       = 17'd0;
            err_seen_next  = 1'b0;
        end
        else if (pos_cur <= LAST_DIGIT_POS)
        begin
            err_seen_next = err_seen_reg || !digit_ok;
            acc_next      = acc_scaled[16:0];
            emit          = (pos_cur == LAST_DIGIT_POS);
        end

        done   = emit && (fc_cur >= LAST_FIELD);
        linear = LIN_W'(fc_cur) * LIN_W'(FIELD_BYTES) + LIN_W'(pos_cur);

        // frame ends on the last field or on the frame length bound
        if (done || (linear >= LAST_LINEAR))
        begin
            byte_pos_next  = 3'd0;
            field_cnt_next = 3'd0;
        end
        else if (pos_cur >= LAST_FIELD_POS)
        begin
            byte_pos_next  = 3'd0;
            field_cnt_next = fc_cur + 3'd1;
        end
        else
        begin
            byte_pos_next  = pos_cur + 3'd1;
            field_cnt_next = fc_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= 3'd0;
            field_cnt_reg <= 3'd0;
            acc_reg       <= 17'd0;
            sign_plus_reg <= 1'b1;
            err_seen_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            byte_pos_reg  <= byte_pos_next;
            field_cnt_reg <= field_cnt_next;
            acc_reg       <= acc_next;
            sign_plus_reg <= sign_plus_next;
            err_seen_reg  <= err_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: completed magnitude and sign
    // ------------------------------------------------------------------
    logic [16:0] s1_mag_reg;
    logic        s1_plus_reg;
    aafsp_tag_t  s1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_room)
            s1_valid_reg <= in_fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_room && in_fire && emit)
        begin
            s1_mag_reg       <= acc_next;
            s1_plus_reg      <= sign_plus_next;
            s1_tag_reg.field <= fc_cur;
            s1_tag_reg.err   <= err_seen_next;
            s1_tag_reg.done  <= done;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: clamp, move from center, saturate
    // ------------------------------------------------------------------
    logic [16:0] mag_clamped;
    logic [17:0] angle_sum;
    logic [16:0] angle_calc;
    logic [16:0] s2_angle_reg;
    aafsp_tag_t  s2_tag_reg;

    always_comb
    begin
        mag_clamped = (s1_mag_reg > max_mag_reg) ? max_mag_reg : s1_mag_reg;
        angle_sum   = {1'b0, center_reg} + {1'b0, mag_clamped};
        if (s1_plus_reg)
            angle_calc = angle_sum[17] ? ANGLE_MAX : angle_sum[16:0];
        else
            angle_calc = (mag_clamped > center_reg) ? 17'd0 : center_reg - mag_clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_room)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_room && s1_valid_reg)
        begin
            s2_angle_reg <= angle_calc;
            s2_tag_reg   <= s1_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: angle / 9 by reciprocal multiply
    // ------------------------------------------------------------------
    logic [33:0]       quot_prod;
    logic [QUOT_W-1:0] s3_quot_reg;
    logic [16:0]       s3_angle_reg;
    aafsp_tag_t        s3_tag_reg;

    assign quot_prod = s2_angle_reg * RECIP_NINE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_room)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_room && s2_valid_reg)
        begin
            s3_quot_reg  <= quot_prod[DIV_SHIFT +: QUOT_W];
            s3_angle_reg <= s2_angle_reg;
            s3_tag_reg   <= s2_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register: add offset, saturate compare
    // ------------------------------------------------------------------
    logic [16:0] cmp_sum;
    logic [15:0] cmp_calc;
    logic [16:0] out_angle_reg;
    logic [15:0] out_cmp_reg;
    aafsp_tag_t  out_tag_reg;

    assign cmp_sum  = {3'd0, s3_quot_reg} + {1'b0, offset_reg};
    assign cmp_calc = cmp_sum[16] ? COMPARE_MAX : cmp_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_room)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_room && s3_valid_reg)
        begin
            out_angle_reg <= s3_angle_reg;
            out_cmp_reg   <= cmp_calc;
            out_tag_reg   <= s3_tag_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign field_index   = out_tag_reg.field;
    assign target_angle  = out_angle_reg;
    assign servo_compare = out_cmp_reg;
    assign digit_error   = out_tag_reg.err;
    assign frame_done    = out_tag_reg.done;

endmodule

@@ sv/aafsp_checker.sv @@
// ----------------------------------------------------------------------------
// ASCII angle frame to servo pulse: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascii_angle_frame_to_servo_pulse_defines.svh"

module aafsp_checker
    import aafsp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [7:0]        rx_byte,
    input logic              frame_start,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        field_index,
    input logic [16:0]       target_angle,
    input logic [15:0]       servo_compare,
    input logic              digit_error,
    input logic              frame_done,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // stalled result holds
    `AAFSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(target_angle) && $stable(servo_compare) && $stable(field_index))

    // last field of a frame carries the done flag, earlier fields never do
    `AAFSP_ASSERT_IMP(a_done_field, clk, rst_n, out_valid && frame_done, field_index == LAST_FIELD)
    `AAFSP_ASSERT_IMP(a_field_range, clk, rst_n, out_valid && !frame_done, field_index < LAST_FIELD)

    // a written clamp limit reads back on the following cycle
    `AAFSP_ASSERT_NEXT(a_cfg_readback, clk, rst_n, psel && penable && pwrite && pready && (paddr[3:2] == REG_MAX_MAG), !(psel && !pwrite && (paddr[3:2] == REG_MAX_MAG)) || (prdata == {15'd0, $past(pwdata[16:0])}))

endmodule

bind ascii_angle_frame_to_servo_pulse aafsp_checker u_aafsp_checker (.*);
